// ----- hdl/pst_pkg.sv -----
// ----------------------------------------------------------------------------
// pst_pkg
// Types and constants shared by the packet sequence tracker.
// ----------------------------------------------------------------------------
`default_nettype none

package pst_pkg;

  // width of the internal timeline index (32 to 64)
  localparam int IndexWidth = 48;

  localparam int SeqWidth   = 16;
  localparam int SlotWidth  = 48;
  localparam int GapWidth   = 15;
  localparam int CountWidth = 32;

  localparam int CfgIndexWidth = 1;
  localparam int CfgDataWidth  = 16;

  localparam logic [CfgIndexWidth-1:0] RegResyncThreshold = 1'd0;
  localparam logic [CfgIndexWidth-1:0] RegFillMaxPackets  = 1'd1;

  localparam logic [15:0]         ResyncThresholdReset = 16'd1000;
  localparam logic [GapWidth-1:0] FillMaxPacketsReset  = 15'd50;

  typedef enum logic [1:0] {
    ACT_PLAY    = 2'd0,
    ACT_DROP    = 2'd1,
    ACT_CONCEAL = 2'd2,
    ACT_RESYNC  = 2'd3
  } action_t;

  typedef struct packed {
    logic [SeqWidth-1:0]  seq_num;
    logic [SlotWidth-1:0] wall_slot;
  } in_item_t;

  typedef struct packed {
    action_t               action;
    logic [SlotWidth-1:0]  timeline_index;
    logic [GapWidth-1:0]   gap_count;
    logic [CountWidth-1:0] dup_total;
    logic [CountWidth-1:0] late_total;
    logic [CountWidth-1:0] lost_total;
    logic [CountWidth-1:0] concealed_total;
    logic [CountWidth-1:0] resync_total;
  } out_item_t;

endpackage

`default_nettype wire

// ----- hdl/packet_sequence_tracker_core.sv -----
// ----------------------------------------------------------------------------
// packet_sequence_tracker_core
// Classifies each packet by its sequence number against the last one kept
// (play, drop, conceal or resync), tracks the timeline index and keeps
// running loss statistics.
// ----------------------------------------------------------------------------
//
//   port group  direction  flow control     transfer when
//   in_*        input      valid / stall    in_valid & !in_stall
//   out_*       output     valid / stall    out_valid & !out_stall
//   cfg_*       input      valid / ready    cfg_valid & cfg_ready
//
// one packet per cycle sustained while out_stall stays low; a packet passes from input
// transfer to result through the input register, then decision logic into the result register.
// the decision path is one 16-bit subtract and compare plus a 48-bit add
// and compare for the index.
// rst is synchronous: the tracker is unanchored, counters clear and the
// registers return to their reset values.
// a stalled result holds in the output register; the input register keeps
// one further packet, then in_stall rises.
// ----------------------------------------------------------------------------
`default_nettype none

module packet_sequence_tracker_core (
  input  wire                                   clk,
  input  wire                                   rst,
  input  wire                                   in_valid,
  output logic                                  in_stall,
  input  pst_pkg::in_item_t                     in_data,
  output logic                                  out_valid,
  input  wire                                   out_stall,
  output pst_pkg::out_item_t                    out_data,
  input  wire                                   cfg_valid,
  output logic                                  cfg_ready,
  input  wire [pst_pkg::CfgIndexWidth-1:0]      cfg_index,
  input  wire [pst_pkg::CfgDataWidth-1:0]       cfg_data
);

  localparam int IdxW = pst_pkg::IndexWidth;
  localparam int SeqW = pst_pkg::SeqWidth;
  localparam int GapW = pst_pkg::GapWidth;
  localparam int CntW = pst_pkg::CountWidth;

  // configuration
  logic [15:0]     resync_threshold;
  logic [GapW-1:0] fill_max_packets;

  // tracker state
  logic            anchored;
  logic [SeqW-1:0] prev_seq;
  logic [IdxW-1:0] cur_index;
  logic [CntW-1:0] dup_count;
  logic [CntW-1:0] late_count;
  logic [CntW-1:0] lost_count;
  logic [CntW-1:0] conceal_count;
  logic [CntW-1:0] resync_count;

  // input register
  logic               hold_valid;
  pst_pkg::in_item_t  hold;

  logic advance;
  logic process;

  // next state
  logic            anchored_next;
  logic [SeqW-1:0] prev_seq_next;
  logic [IdxW-1:0] cur_index_next;
  logic [CntW-1:0] dup_count_next;
  logic [CntW-1:0] late_count_next;
  logic [CntW-1:0] lost_count_next;
  logic [CntW-1:0] conceal_count_next;
  logic [CntW-1:0] resync_count_next;
  pst_pkg::action_t action_next;
  logic [GapW-1:0] gap_next;

  // decision terms
  logic [SeqW-1:0] diff;
  logic            diff_neg;
  logic            diff_zero;
  logic            diff_one;
  logic [SeqW-1:0] back_mag;
  logic [SeqW-1:0] gap_raw;
  logic            is_drop;
  logic            is_fwd_gap;
  logic            is_conceal;
  logic [IdxW-1:0] wall;
  logic [IdxW-1:0] index_inc;
  logic [IdxW-1:0] index_gap;
  logic [IdxW-1:0] index_resync;

  assign cfg_ready = 1'b1;

  assign advance  = !out_valid || !out_stall;
  assign process  = hold_valid && advance;
  assign in_stall = hold_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      resync_threshold <= pst_pkg::ResyncThresholdReset;
      fill_max_packets <= pst_pkg::FillMaxPacketsReset;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        pst_pkg::RegResyncThreshold: resync_threshold <= cfg_data;
        pst_pkg::RegFillMaxPackets:  fill_max_packets <= cfg_data[GapW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (in_valid && !in_stall) begin
      hold_valid <= 1'b1;
    end else if (process) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      hold <= in_data;
    end
  end

  always_comb begin
    diff      = hold.seq_num - prev_seq;
    diff_neg  = diff[SeqW-1];
    diff_zero = (diff == '0);
    diff_one  = (diff == SeqW'(1));
    back_mag  = SeqW'(0) - diff;
    gap_raw   = diff - SeqW'(1);
    // a zero step is a duplicate unless the threshold is zero
    is_drop    = (diff_neg || diff_zero) && (back_mag < resync_threshold);
    is_fwd_gap = !diff_neg && !diff_zero && !diff_one;
    is_conceal = is_fwd_gap && (gap_raw[GapW-1:0] <= fill_max_packets);

    wall         = IdxW'(hold.wall_slot);
    index_inc    = cur_index + IdxW'(1);
    index_gap    = cur_index + IdxW'(diff);
    index_resync = (wall > index_inc) ? wall : index_inc;

    anchored_next      = anchored;
    prev_seq_next      = prev_seq;
    cur_index_next     = cur_index;
    dup_count_next     = dup_count;
    late_count_next    = late_count;
    lost_count_next    = lost_count;
    conceal_count_next = conceal_count;
    resync_count_next  = resync_count;
    action_next        = pst_pkg::ACT_PLAY;
    gap_next           = '0;

    if (!anchored) begin
      anchored_next  = 1'b1;
      prev_seq_next  = hold.seq_num;
      cur_index_next = '0;
    end else if (diff_one) begin
      prev_seq_next  = hold.seq_num;
      cur_index_next = index_inc;
    end else if (is_drop) begin
      action_next = pst_pkg::ACT_DROP;
      if (diff_zero) begin
        dup_count_next = dup_count + CntW'(1);
      end else begin
        late_count_next = late_count + CntW'(1);
      end
    end else if (is_conceal) begin
      action_next        = pst_pkg::ACT_CONCEAL;
      gap_next           = gap_raw[GapW-1:0];
      lost_count_next    = lost_count + CntW'(gap_raw);
      conceal_count_next = conceal_count + CntW'(gap_raw);
      cur_index_next     = index_gap;
      prev_seq_next      = hold.seq_num;
    end else begin
      action_next       = pst_pkg::ACT_RESYNC;
      resync_count_next = resync_count + CntW'(1);
      if (is_fwd_gap) begin
        lost_count_next = lost_count + CntW'(gap_raw);
      end
      cur_index_next = index_resync;
      prev_seq_next  = hold.seq_num;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      anchored      <= 1'b0;
      prev_seq      <= '0;
      cur_index     <= '0;
      dup_count     <= '0;
      late_count    <= '0;
      lost_count    <= '0;
      conceal_count <= '0;
      resync_count  <= '0;
    end else if (process) begin
      anchored      <= anchored_next;
      prev_seq      <= prev_seq_next;
      cur_index     <= cur_index_next;
      dup_count     <= dup_count_next;
      late_count    <= late_count_next;
      lost_count    <= lost_count_next;
      conceal_count <= conceal_count_next;
      resync_count  <= resync_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= hold_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (process) begin
      out_data.action          <= action_next;
      out_data.timeline_index  <= pst_pkg::SlotWidth'(cur_index_next);
      out_data.gap_count       <= gap_next;
      out_data.dup_total       <= dup_count_next;
      out_data.late_total      <= late_count_next;
      out_data.lost_total      <= lost_count_next;
      out_data.concealed_total <= conceal_count_next;
      out_data.resync_total    <= resync_count_next;
    end
  end

endmodule

`default_nettype wire

// ----- verif/tb_packet_sequence_tracker_core.sv -----
// ----------------------------------------------------------------------------
// tb_packet_sequence_tracker_core
// Self-checking bench for the packet sequence tracker. A queue of packets
// (directed corner cases, then runs of in-order sequence numbers broken by
// duplicates, late packets, gaps and jumps) feeds a clocked driver. A clocked
// monitor classifies every accepted packet with its own tracker model and
// checks each result field against the oldest prediction. Register settings
// change between phases, with random idling on both sides and one long
// output hold-off that backs the block up.
// ----------------------------------------------------------------------------

module tb_packet_sequence_tracker_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int StuckLimit = 3000;
  localparam int HoldCycles = 80;

  logic clk;
  logic rst = 1'b1;

  logic               in_valid = 1'b0;
  logic               in_stall;
  pst_pkg::in_item_t  in_data = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  pst_pkg::out_item_t out_data;
  logic                              cfg_valid = 1'b0;
  logic                              cfg_ready;
  logic [pst_pkg::CfgIndexWidth-1:0] cfg_index = pst_pkg::RegResyncThreshold;
  logic [pst_pkg::CfgDataWidth-1:0]  cfg_data = '0;

  packet_sequence_tracker_core i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // tracker model state
  int                             late_limit = pst_pkg::ResyncThresholdReset;
  int                             fill_limit = pst_pkg::FillMaxPacketsReset;
  bit                             locked;
  logic [pst_pkg::SeqWidth-1:0]   kept_seq = '0;
  logic [pst_pkg::IndexWidth-1:0] timeline = '0;
  logic [pst_pkg::CountWidth-1:0] n_dup = '0;
  logic [pst_pkg::CountWidth-1:0] n_late = '0;
  logic [pst_pkg::CountWidth-1:0] n_lost = '0;
  logic [pst_pkg::CountWidth-1:0] n_concealed = '0;
  logic [pst_pkg::CountWidth-1:0] n_resync = '0;

  pst_pkg::in_item_t  packet_queue[$];
  pst_pkg::out_item_t expected_results[$];
  logic [pst_pkg::SeqWidth-1:0] gen_seq = 16'd65533;

  int  queued_cnt, accepted_cnt, errors, stuck_cycles, in_blocked_cycles;
  int  action_seen[4];
  int  send_idle_pct = 25;
  int  recv_stall_pct = 25;
  bit  hold_request, hold_done, in_taken;
  int  hold_left;

  function automatic pst_pkg::out_item_t track_packet(pst_pkg::in_item_t pkt);
    pst_pkg::out_item_t             res;
    logic [pst_pkg::SeqWidth-1:0]   raw;
    logic [pst_pkg::IndexWidth-1:0] nxt, slot;
    int                             diff;
    res = '0;
    raw = pkt.seq_num - kept_seq;
    diff = $signed(raw);
    if (!locked) begin
      locked = 1'b1;
      kept_seq = pkt.seq_num;
      timeline = '0;
      res.action = pst_pkg::ACT_PLAY;
    end else if (diff == 1) begin
      timeline = timeline + 1'b1;
      kept_seq = pkt.seq_num;
      res.action = pst_pkg::ACT_PLAY;
    end else if (diff <= 0 && diff > -late_limit) begin
      if (diff == 0) n_dup = n_dup + 1'b1;
      else n_late = n_late + 1'b1;
      res.action = pst_pkg::ACT_DROP;
    end else if (diff > 1 && diff - 1 <= fill_limit) begin
      n_lost = n_lost + (diff - 1);
      n_concealed = n_concealed + (diff - 1);
      timeline = timeline + diff;
      kept_seq = pkt.seq_num;
      res.action = pst_pkg::ACT_CONCEAL;
      res.gap_count = diff - 1;
    end else begin
      if (diff > 1) n_lost = n_lost + (diff - 1);
      n_resync = n_resync + 1'b1;
      nxt = timeline + 1'b1;
      slot = pkt.wall_slot;
      if (slot > nxt) nxt = slot;
      timeline = nxt;
      kept_seq = pkt.seq_num;
      res.action = pst_pkg::ACT_RESYNC;
    end
    res.timeline_index  = timeline;
    res.dup_total       = n_dup;
    res.late_total      = n_late;
    res.lost_total      = n_lost;
    res.concealed_total = n_concealed;
    res.resync_total    = n_resync;
    return res;
  endfunction

  function automatic void flag_error(string msg);
    errors++;
    if (errors <= 10) $display("%t: %s", $realtime, msg);
  endfunction

  // queue the packet that lies diff steps after the last kept sequence number
  task automatic push_packet(int diff, logic [pst_pkg::SlotWidth-1:0] slot);
    pst_pkg::in_item_t pkt;
    pkt.seq_num = gen_seq + diff[15:0];
    pkt.wall_slot = slot;
    if (!(diff <= 0 && diff > -late_limit)) gen_seq = pkt.seq_num;
    packet_queue.push_back(pkt);
    queued_cnt++;
  endtask

  task automatic queue_stream(int count);
    int                            diff, pick;
    bit                            edge_case;
    logic [63:0]                   r;
    logic [pst_pkg::SlotWidth-1:0] slot;
    repeat (count) begin
      pick = $urandom_range(0, 99);
      edge_case = ($urandom_range(0, 2) == 0);
      if (pick < 68) begin
        diff = 1;
      end else if (pick < 74) begin
        diff = 0;
      end else if (pick < 81) begin
        if (late_limit > 1)
          diff = edge_case ? -(late_limit - 1) : -int'($urandom_range(1, late_limit - 1));
        else diff = 0;
      end else if (pick < 89) begin
        if (fill_limit >= 1)
          diff = edge_case ? fill_limit + 1
                           : 1 + int'($urandom_range(1, (fill_limit < 64) ? fill_limit : 64));
        else diff = 2;
      end else if (pick < 94) begin
        if (fill_limit + 2 <= 32767)
          diff = edge_case ? fill_limit + 2 : int'($urandom_range(fill_limit + 2, 32767));
        else diff = 32767;
      end else if (pick < 98) begin
        diff = edge_case ? -late_limit : -int'($urandom_range(late_limit, 32768));
      end else begin
        diff = int'($urandom_range(0, 65535)) - 32768;
      end
      r = {$urandom(), $urandom()};
      case ($urandom_range(0, 9))
        0:       slot = '0;
        1:       slot = '1;
        2, 3, 4: slot = $urandom_range(0, 1000);
        default: slot = r[pst_pkg::SlotWidth-1:0];
      endcase
      push_packet(diff, slot);
    end
  endtask

  task automatic write_reg(logic [pst_pkg::CfgIndexWidth-1:0] idx,
                           logic [pst_pkg::CfgDataWidth-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == pst_pkg::RegResyncThreshold) late_limit = val;
    else fill_limit = val[pst_pkg::GapWidth-1:0];
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // every queued packet taken and every result back, then a short settle
  task automatic drain();
    while (accepted_cnt < queued_cnt || expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  always @(negedge clk) begin : driver
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (packet_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        in_data  <= packet_queue.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin : receiver
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else if (hold_request && !hold_done) begin
      hold_left <= HoldCycles;
      hold_done <= 1'b1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  always @(posedge clk) begin : monitor
    pst_pkg::out_item_t want;
    bit                 busy;
    in_taken <= in_valid && !in_stall && !rst;
    if (!rst) begin
      busy = cfg_valid && cfg_ready;
      if (out_valid && !out_stall) begin
        busy = 1'b1;
        if (expected_results.size() == 0) begin
          flag_error($sformatf("result with nothing expected: %h", out_data));
        end else begin
          want = expected_results.pop_front();
          if (out_data.action !== want.action ||
              out_data.timeline_index !== want.timeline_index ||
              out_data.gap_count !== want.gap_count ||
              out_data.dup_total !== want.dup_total ||
              out_data.late_total !== want.late_total ||
              out_data.lost_total !== want.lost_total ||
              out_data.concealed_total !== want.concealed_total ||
              out_data.resync_total !== want.resync_total)
            flag_error($sformatf({"result differs\n",
              "  expected act %0d idx %h gap %0d dup %0d late %0d lost %0d conc %0d rsy %0d\n",
              "  actual   act %0d idx %h gap %0d dup %0d late %0d lost %0d conc %0d rsy %0d"},
              want.action, want.timeline_index, want.gap_count, want.dup_total,
              want.late_total, want.lost_total, want.concealed_total, want.resync_total,
              out_data.action, out_data.timeline_index, out_data.gap_count,
              out_data.dup_total, out_data.late_total, out_data.lost_total,
              out_data.concealed_total, out_data.resync_total));
        end
      end
      if (in_valid && in_stall) in_blocked_cycles++;
      if (in_valid && !in_stall) begin
        busy = 1'b1;
        want = track_packet(in_data);
        action_seen[want.action]++;
        expected_results.push_back(want);
        accepted_cnt++;
      end
      stuck_cycles = busy ? 0 : stuck_cycles + 1;
      if (stuck_cycles == StuckLimit) begin
        $display("no transfer for %0d cycles", StuckLimit);
        $display("packet_sequence_tracker_core: mismatch");
        $finish;
      end
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // corner cases under the reset register values
    push_packet(1, '1);                    // first packet anchors at index 0
    push_packet(1, '0);
    push_packet(1, '0);                    // sequence number wraps to 0
    push_packet(0, '0);                    // duplicate
    push_packet(-1, '0);                   // late
    push_packet(-999, '0);                 // oldest still dropped as late
    push_packet(-1000, '0);                // threshold reached: resync to index + 1
    push_packet(51, '0);                   // largest concealed gap
    push_packet(52, '1);                   // one past it: resync to the wall slot
    push_packet(1, '0);                    // index wraps to 0
    push_packet(2, '0);
    push_packet(32767, 48'h5555_5555_5555); // largest forward step
    push_packet(-32768, 48'hAAAA_AAAA_AAAA);
    push_packet(-5000, 48'h0000_0000_0001);
    push_packet(100, 48'h8000_0000_0000);  // wall slot behind the index
    push_packet(0, '0);
    push_packet(1, '0);
    queue_stream(60);
    drain();

    // widest drop window and largest fill
    write_reg(pst_pkg::RegResyncThreshold, 16'd32768);
    write_reg(pst_pkg::RegFillMaxPackets, 16'd32766);
    queue_stream(100);
    drain();

    // narrowest settings: every backward step and every gap resyncs
    write_reg(pst_pkg::RegResyncThreshold, 16'd1);
    write_reg(pst_pkg::RegFillMaxPackets, 16'd0);
    queue_stream(100);
    drain();

    // no idling, one long hold-off on the output side
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    write_reg(pst_pkg::RegResyncThreshold, 16'($urandom_range(2, 32767)));
    write_reg(pst_pkg::RegFillMaxPackets, 16'($urandom_range(1, 32765)));
    hold_request = 1'b1;
    queue_stream(120);
    drain();
    hold_request   = 1'b0;
    send_idle_pct  = 25;
    recv_stall_pct = 25;

    write_reg(pst_pkg::RegResyncThreshold, 16'($urandom_range(1, 200)));
    write_reg(pst_pkg::RegFillMaxPackets, 16'($urandom_range(0, 8)));
    queue_stream(120);
    drain();

    repeat (10) @(posedge clk);
    if (expected_results.size() != 0)
      flag_error($sformatf("%0d results never arrived", expected_results.size()));
    $display("%0d packets over five register settings: play %0d, drop %0d, conceal %0d, %s %0d",
             accepted_cnt, action_seen[pst_pkg::ACT_PLAY], action_seen[pst_pkg::ACT_DROP],
             action_seen[pst_pkg::ACT_CONCEAL], "resync", action_seen[pst_pkg::ACT_RESYNC]);
    $display("input held back for %0d cycles, %0d errors", in_blocked_cycles, errors);
    if (errors == 0) begin
      $display("packet_sequence_tracker_core: match");
    end else begin
      $display("packet_sequence_tracker_core: mismatch");
    end
    $finish;
  end

endmodule
